// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the histogram binner checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define RHB_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rhb check failed");

// antecedent implies consequent in the next cycle
`define RHB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rhb check failed");

`endif

// ===== src/rhb_pkg.sv =====
// ----------------------------------------------------------------------------
// rhb_pkg
// types, constants and state codes of the fixed range histogram binner
// ----------------------------------------------------------------------------
package rhb_pkg;

    localparam int DATA_W       = 32;
    localparam int BINS_W       = 7;
    localparam int BIN_IDX_W    = 6;
    localparam int PROD_W       = DATA_W + BINS_W;
    localparam int DIV_STEPS    = BINS_W;
    localparam int STEP_W       = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int MAX_BINS_DEF = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE = 2'd2;

    localparam logic [DATA_W-1:0] RANGE_MIN_RST   = 32'd0;
    localparam logic [DATA_W-1:0] RANGE_MAX_RST   = 32'd65536;
    localparam logic [BINS_W-1:0] BINS_IN_USE_RST = 7'd64;

    localparam logic [DATA_W-1:0] COUNT_SAT = '1;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample_value;
        logic                     included;
        logic                     end_of_pass;
    } t_sample;

    typedef struct packed {
        logic [BIN_IDX_W-1:0] bin_index;
        logic [DATA_W-1:0]    bin_total;
        logic                 last_bin;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPAN,
        ST_MUL,
        ST_DIV,
        ST_RD,
        ST_WR,
        ST_DRD,
        ST_DLD
    } t_state;

endpackage

// ===== src/range_histogram_binner_unit.sv =====
// ----------------------------------------------------------------------------
// range_histogram_binner_unit
// fixed range histogram over signed Q16.16 samples with readout on pass end
// ----------------------------------------------------------------------------
//  channel   | signals                          | direction
//  ----------+----------------------------------+----------
//  sample    | i_valid, o_ready, i_sample       | in
//  bin       | o_valid, i_ready, o_result       | out
//  config    | i_cfg_we, i_cfg_index, i_cfg_data| in
//
//  a counted sample keeps o_ready low after its request through range check,
//  multiply, the serial divider, then read and write of the count memory;
//  a skipped sample keeps it low for the range check only
//  readout does a memory read, then an output load, for each bin while the sink
//  is ready; the output register stalls the readout when it is not taken
//  reset clears the counts through valid bits, no sweep
// ----------------------------------------------------------------------------
module range_histogram_binner_unit import rhb_pkg::*; #(
    parameter int MAX_BINS = MAX_BINS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_sample              i_sample,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_result              o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data
);

    localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

    t_state r_state;
    t_state n_state;

    logic signed [DATA_W-1:0] r_range_min;
    logic signed [DATA_W-1:0] r_range_max;
    logic [BINS_W-1:0]        r_bins_in_use;

    t_sample            r_sample;
    logic               r_counted;
    logic               r_eop;
    logic               r_span_zero;
    logic [DATA_W-1:0]  r_off;
    logic [DATA_W-1:0]  r_span;
    logic [AW-1:0]      r_idx;
    logic               r_out_valid;
    t_result            r_out;

    logic [BINS_W-1:0]  w_bins;
    logic [DATA_W:0]    w_off;
    logic [DATA_W:0]    w_span;
    logic [PROD_W-1:0]  w_prod;
    logic               w_in_range;
    logic               w_div_done;
    logic [BINS_W-1:0]  w_quo;
    logic [BINS_W-1:0]  w_bin_sel;
    logic [DATA_W-1:0]  w_rd_data;
    logic [DATA_W-1:0]  w_wr_data;
    logic               w_last;
    logic               w_load;
    logic               w_rd_en;
    logic [AW-1:0]      w_rd_addr;
    logic               w_wr_en;
    logic               w_div_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_min   <= RANGE_MIN_RST;
            r_range_max   <= RANGE_MAX_RST;
            r_bins_in_use <= BINS_IN_USE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RANGE_MIN:   r_range_min   <= i_cfg_data;
                CFG_RANGE_MAX:   r_range_max   <= i_cfg_data;
                CFG_BINS_IN_USE: r_bins_in_use <= i_cfg_data[BINS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_bins_in_use == '0) begin
            w_bins = BINS_W'(1);
        end else if (r_bins_in_use > BINS_W'(MAX_BINS)) begin
            w_bins = BINS_W'(MAX_BINS);
        end else begin
            w_bins = r_bins_in_use;
        end
    end

    assign w_off      = {r_sample.sample_value[DATA_W-1], r_sample.sample_value}
                      - {r_range_min[DATA_W-1], r_range_min};
    assign w_span     = {r_range_max[DATA_W-1], r_range_max}
                      - {r_range_min[DATA_W-1], r_range_min};
    assign w_in_range = (r_sample.sample_value >= r_range_min)
                     && (r_sample.sample_value <= r_range_max);
    assign w_prod     = PROD_W'(r_off) * PROD_W'(w_bins);

    always_comb begin
        if (r_span_zero) begin
            w_bin_sel = '0;
        end else if (w_quo >= w_bins) begin
            w_bin_sel = w_bins - BINS_W'(1);
        end else begin
            w_bin_sel = w_quo;
        end
    end

    assign w_wr_data = (w_rd_data == COUNT_SAT) ? w_rd_data : w_rd_data + DATA_W'(1);
    assign w_last    = BINS_W'(r_idx) == (w_bins - BINS_W'(1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_SPAN;
                end
            end
            ST_SPAN: begin
                if (r_sample.included && w_in_range) begin
                    n_state = ST_MUL;
                end else if (r_sample.end_of_pass) begin
                    n_state = ST_DRD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_MUL: n_state = ST_DIV;
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_RD;
                end
            end
            ST_RD: n_state = ST_WR;
            ST_WR: n_state = r_eop ? ST_DRD : ST_IDLE;
            ST_DRD: n_state = ST_DLD;
            ST_DLD: begin
                if (w_load) begin
                    n_state = w_last ? ST_IDLE : ST_DRD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready     = r_state == ST_IDLE;
        w_div_start = r_state == ST_MUL;
        w_rd_en     = (r_state == ST_RD) || (r_state == ST_DRD);
        w_rd_addr   = (r_state == ST_RD) ? w_bin_sel[AW-1:0] : r_idx;
        w_wr_en     = r_state == ST_WR;
        w_load      = (r_state == ST_DLD) && (!r_out_valid || i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sample <= i_sample;
        end
        if (r_state == ST_SPAN) begin
            r_counted   <= r_sample.included && w_in_range;
            r_eop       <= r_sample.end_of_pass;
            r_off       <= w_off[DATA_W-1:0];
            r_span      <= w_span[DATA_W-1:0];
            r_span_zero <= r_range_max == r_range_min;
        end
        case (r_state)
            ST_SPAN: r_idx <= '0;
            ST_RD:   r_idx <= w_bin_sel[AW-1:0];
            ST_WR:   r_idx <= '0;
            ST_DLD: begin
                if (w_load && !w_last) begin
                    r_idx <= r_idx + AW'(1);
                end
            end
            default: ;
        endcase
        if (w_load) begin
            r_out.bin_index <= BIN_IDX_W'(r_idx);
            r_out.bin_total <= w_rd_data;
            r_out.last_bin  <= w_last;
        end
    end

    rhb_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_prod),
        .i_divisor  (r_span),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    rhb_count_mem #(
        .MAX_BINS (MAX_BINS),
        .AW       (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en && r_counted),
        .i_wr_addr (r_idx),
        .i_wr_data (w_wr_data),
        .i_clear   (w_load && w_last)
    );

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== src/rhb_divider.sv =====
// ----------------------------------------------------------------------------
// rhb_divider
// restoring divider, one quotient bit per cycle, for the bin index
// ----------------------------------------------------------------------------
module rhb_divider import rhb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [PROD_W-1:0]    i_dividend,
    input  logic [DATA_W-1:0]    i_divisor,
    output logic                 o_done,
    output logic [BINS_W-1:0]    o_quotient
);

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_cnt;
    logic [DATA_W-1:0]   r_rem;
    logic [BINS_W-1:0]   r_low;
    logic [BINS_W-1:0]   r_quo;
    logic [DATA_W-1:0]   r_div;

    logic [DATA_W:0]     w_shift;
    logic [DATA_W:0]     w_diff;
    logic                w_ge;

    // quotient never exceeds the bin count, so the top bits start as remainder
    assign w_shift = {r_rem, r_low[BINS_W-1]};
    assign w_diff  = w_shift - {1'b0, r_div};
    assign w_ge    = w_shift >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + STEP_W'(1);
                if (r_cnt == STEP_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[PROD_W-1:BINS_W];
            r_low <= i_dividend[BINS_W-1:0];
            r_div <= i_divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DATA_W-1:0] : w_shift[DATA_W-1:0];
            r_low <= {r_low[BINS_W-2:0], 1'b0};
            r_quo <= {r_quo[BINS_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== src/rhb_count_mem.sv =====
// ----------------------------------------------------------------------------
// rhb_count_mem
// bin count memory with one registered read port, one write port and
// per-entry valid bits so that a cleared entry reads as zero
// ----------------------------------------------------------------------------
module rhb_count_mem import rhb_pkg::*; #(
    parameter int MAX_BINS = MAX_BINS_DEF,
    parameter int AW       = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_clear
);

    logic [DATA_W-1:0]   r_mem [MAX_BINS];
    logic [MAX_BINS-1:0] r_valid;
    logic [DATA_W-1:0]   r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_clear) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_valid[i_rd_addr] ? r_mem[i_rd_addr] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/rhb_checker.sv =====
// ----------------------------------------------------------------------------
// rhb_checker
// port level checks of the histogram binner, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rhb_checker import rhb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 o_ready,
    input  t_sample              i_sample,
    input  logic                 o_valid,
    input  logic                 i_ready,
    input  t_result              o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data
);

    logic                 r_mid_run;
    logic [BIN_IDX_W-1:0] r_next_idx;
    logic                 w_out_take;
    logic                 w_cfg_seen;

    assign w_out_take = o_valid && i_ready;
    assign w_cfg_seen = i_cfg_we && (i_cfg_index == CFG_BINS_IN_USE) && (i_cfg_data == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_run  <= 1'b0;
            r_next_idx <= '0;
        end else if (w_out_take) begin
            r_mid_run  <= !o_result.last_bin;
            r_next_idx <= o_result.bin_index + BIN_IDX_W'(1);
        end
    end

    // stalled bin holds
    `RHB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_result))
    // readout runs through the bins in order from bin zero
    `RHB_ASSERT_SAME(a_bin_order, i_clk, i_rst_n, o_valid, o_result.bin_index == (r_mid_run ? r_next_idx : '0))
    // no new sample is taken while a readout run waits for its next bin
    `RHB_ASSERT_SAME(a_no_accept_mid_run, i_clk, i_rst_n, r_mid_run && !o_valid, !o_ready)
    // one sample at a time: busy right after a request
    `RHB_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    // a run that writes a zero bin count still ends after bin zero
    `RHB_ASSERT_NEXT(a_single_bin_last, i_clk, i_rst_n, w_cfg_seen, !(o_valid && !r_mid_run && !o_result.last_bin && r_next_idx != '0))

endmodule

bind range_histogram_binner_unit rhb_checker u_rhb_checker (.*);

// ===== verif/range_histogram_binner_unit_tb.sv =====
// ----------------------------------------------------------------------------
// range_histogram_binner_unit_tb
// self-checking bench for the fixed range histogram binner: samples are sent
// in passes under directed and random range settings, a local bin tally
// predicts every readout, and each bin request is compared field by field
// while both the sample sender and the bin sink idle at random
// ----------------------------------------------------------------------------
module range_histogram_binner_unit_tb import rhb_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int                   TB_MAX_BINS   = MAX_BINS_DEF;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 2'd3;
    localparam int                   DRAIN_CYCLES  = 16;
    localparam int                   RANDOM_ITEMS  = 245;
    localparam int                   REPORT_LIMIT  = 10;
    localparam int                   TIMEOUT_NS    = 10_000_000;

    typedef enum logic [1:0] {
        SINK_FREE,
        SINK_EVERY4,
        SINK_COIN,
        SINK_SLOW
    } t_sink_mode;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_ready;
    t_sample              i_sample    = '0;
    logic                 o_valid;
    logic                 i_ready     = 1'b0;
    t_result              o_result;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_RANGE_MIN;
    logic [DATA_W-1:0]    i_cfg_data  = '0;

    // local copy of the block's registers and bin store
    logic signed [DATA_W-1:0] cfg_min  = RANGE_MIN_RST;
    logic signed [DATA_W-1:0] cfg_max  = RANGE_MAX_RST;
    logic [BINS_W-1:0]        cfg_bins = BINS_IN_USE_RST;
    logic [DATA_W-1:0]        tally [TB_MAX_BINS];
    t_result                  pending_bins [$];

    int sent_requests   = 0;
    int results_checked = 0;
    int passes_done     = 0;
    int mismatches      = 0;
    int random_items    = 0;
    int burst_left      = 0;

    logic [31:0] rdy_tick = '0;
    t_sink_mode  rdy_mode = SINK_FREE;

    range_histogram_binner_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_sample    (i_sample),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #TIMEOUT_NS;
        $display("TEST FAILED");
        $finish;
    end

    // sink back-pressure
    always @(posedge i_clk) begin
        rdy_tick <= rdy_tick + 1;
        if (rdy_tick[6:0] == 7'd0) begin
            rdy_mode <= t_sink_mode'($urandom_range(0, 3));
        end
        case (rdy_mode)
            SINK_FREE:   i_ready <= 1'b1;
            SINK_EVERY4: i_ready <= (rdy_tick[1:0] != 2'd3);
            SINK_COIN:   i_ready <= 1'($urandom_range(0, 1));
            default:     i_ready <= (rdy_tick[4:0] < 5'd6);
        endcase
    end

    always @(posedge i_clk) begin : bin_check
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_bins.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("unexpected bin request: idx %0d total %0d last %0b",
                             o_result.bin_index, o_result.bin_total, o_result.last_bin);
                end
            end else begin
                want = pending_bins.pop_front();
                results_checked++;
                if (o_result.bin_index !== want.bin_index ||
                    o_result.bin_total !== want.bin_total ||
                    o_result.last_bin !== want.last_bin) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("bin mismatch: expected idx %0d total %0d last %0b, got idx %0d total %0d last %0b",
                                 want.bin_index, want.bin_total, want.last_bin,
                                 o_result.bin_index, o_result.bin_total, o_result.last_bin);
                    end
                end
            end
        end
    end

    function automatic int live_bins();
        if (cfg_bins == '0) return 1;
        if (cfg_bins > TB_MAX_BINS) return TB_MAX_BINS;
        return int'(cfg_bins);
    endfunction

    // bin a sample lands in, or -1 when it falls outside the range
    function automatic int bin_slot(input logic signed [DATA_W-1:0] x);
        longint lo;
        longint hi;
        longint idx;
        longint nb;
        lo = cfg_min;
        hi = cfg_max;
        nb = live_bins();
        if (x < lo || x > hi) return -1;
        if (hi == lo) return 0;
        idx = ((longint'(x) - lo) * nb) / (hi - lo);
        if (idx >= nb) idx = nb - 1;
        return int'(idx);
    endfunction

    task automatic account_sample(input t_sample s);
        int slot;
        int nb;
        t_result r;
        nb = live_bins();
        if (s.included) begin
            slot = bin_slot(s.sample_value);
            if (slot >= 0 && tally[slot] != COUNT_SAT) tally[slot]++;
        end
        if (s.end_of_pass) begin
            for (int i = 0; i < nb; i++) begin
                r.bin_index = BIN_IDX_W'(i);
                r.bin_total = tally[i];
                r.last_bin  = (i == nb - 1);
                pending_bins.push_back(r);
            end
            foreach (tally[i]) tally[i] = '0;
            passes_done++;
        end
    endtask

    task automatic send_sample(input t_sample s);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid  <= 1'b1;
        i_sample <= s;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sent_requests++;
        account_sample(s);
    endtask

    // wait for every bin request, then let an in-flight sample finish
    task automatic settle();
        i_valid <= 1'b0;
        burst_left = 0;
        while (pending_bins.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_RANGE_MIN:   cfg_min = val;
            CFG_RANGE_MAX:   cfg_max = val;
            CFG_BINS_IN_USE: cfg_bins = val[BINS_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic program_range(input logic signed [DATA_W-1:0] lo,
                                 input logic signed [DATA_W-1:0] hi,
                                 input logic [BINS_W-1:0] nb);
        write_reg(CFG_RANGE_MIN, lo);
        write_reg(CFG_RANGE_MAX, hi);
        write_reg(CFG_BINS_IN_USE, ($urandom & 32'hFFFF_FF80) | DATA_W'(nb));
    endtask

    task automatic test_default_range();
        send_sample('{32'sd0, 1'b1, 1'b0});
        send_sample('{32'sd65536, 1'b1, 1'b0});
        send_sample('{32'sd32768, 1'b1, 1'b0});
        send_sample('{-32'sd1, 1'b1, 1'b0});
        send_sample('{32'sd65537, 1'b1, 1'b0});
        send_sample('{32'sd100, 1'b0, 1'b0});
        send_sample('{32'sd65535, 1'b1, 1'b1});
    endtask

    task automatic test_full_scale_extremes();
        settle();
        program_range(32'sh8000_0000, 32'sh7FFF_FFFF, 7'd64);
        send_sample('{32'sh8000_0000, 1'b1, 1'b0});
        send_sample('{32'sh7FFF_FFFF, 1'b1, 1'b0});
        send_sample('{32'sd0, 1'b1, 1'b0});
        send_sample('{-32'sd1, 1'b1, 1'b0});
        send_sample('{32'sd12345, 1'b0, 1'b1});
    endtask

    task automatic test_bin_count_limits();
        settle();
        program_range(-32'sd65536, 32'sd65536, 7'd0);
        send_sample('{32'sd123, 1'b1, 1'b1});
        settle();
        write_reg(CFG_BINS_IN_USE, 32'hA5A5_A57F);
        send_sample('{32'sd65536, 1'b1, 1'b1});
    endtask

    task automatic test_inverted_and_flat_ranges();
        settle();
        program_range(32'sd100, -32'sd100, 7'd3);
        send_sample('{32'sd0, 1'b1, 1'b1});
        settle();
        program_range(32'sd327680, 32'sd327680, 7'd8);
        send_sample('{32'sd327680, 1'b1, 1'b0});
        send_sample('{32'sd327681, 1'b1, 1'b0});
        send_sample('{32'sd327680, 1'b1, 1'b1});
    endtask

    task automatic test_bins_shrunk_mid_pass();
        settle();
        program_range(32'sd0, 32'sd65536, 7'd64);
        send_sample('{32'sd65536, 1'b1, 1'b0});
        send_sample('{32'sd0, 1'b1, 1'b0});
        settle();
        write_reg(CFG_BINS_IN_USE, 32'd4);
        send_sample('{32'sd16384, 1'b1, 1'b1});
        settle();
        write_reg(CFG_BINS_IN_USE, 32'd64);
        send_sample('{32'sd16384, 1'b0, 1'b1});
    endtask

    task automatic test_spare_register();
        settle();
        write_reg(CFG_SPARE, 32'd1);
        send_sample('{32'sd65536, 1'b1, 1'b1});
    endtask

    task automatic pick_config();
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;
        logic [BINS_W-1:0] nb;
        int mode;
        mode = $urandom_range(0, 9);
        case (mode)
            0: begin
                lo = 32'sh8000_0000;
                hi = 32'sh7FFF_FFFF;
            end
            1: begin
                lo = $urandom;
                hi = lo;
            end
            2: begin
                lo = $urandom;
                hi = $urandom;
            end
            3, 4, 5: begin
                lo = -(DATA_W'($urandom_range(0, 5)) <<< 16);
                hi = DATA_W'($urandom_range(1, 5)) <<< 16;
            end
            default: begin
                lo = $urandom;
                hi = lo + DATA_W'($urandom_range(0, 32'h00FF_FFFF));
            end
        endcase
        mode = $urandom_range(0, 9);
        case (mode)
            0:       nb = '0;
            1:       nb = BINS_W'($urandom_range(65, 127));
            2:       nb = 7'd64;
            default: nb = BINS_W'($urandom_range(1, 16));
        endcase
        program_range(lo, hi, nb);
    endtask

    function automatic t_sample make_sample(input bit eop);
        t_sample s;
        longint lo;
        longint hi;
        longint off;
        int pick;
        lo = cfg_min;
        hi = cfg_max;
        pick = $urandom_range(0, 19);
        s.included    = ($urandom_range(0, 9) != 0);
        s.end_of_pass = eop;
        if (hi < lo || pick < 2) begin
            s.sample_value = $urandom;
        end else if (pick == 2) begin
            s.sample_value = cfg_min;
        end else if (pick == 3) begin
            s.sample_value = cfg_max;
        end else if (pick == 4) begin
            s.sample_value = cfg_min - 1;
        end else if (pick == 5) begin
            s.sample_value = cfg_max + 1;
        end else begin
            off = longint'($urandom) % (hi - lo + 1);
            s.sample_value = DATA_W'(lo + off);
        end
        return s;
    endfunction

    task automatic test_random_passes();
        t_sample s;
        int pass_len;
        while (random_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 2) != 0) begin
                settle();
                pick_config();
            end
            pass_len = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40)
                                                   : $urandom_range(1, 10);
            for (int k = 0; k < pass_len; k++) begin
                // occasionally resize the bin set partway through a pass
                if (k == pass_len / 2 && k > 0 && $urandom_range(0, 9) == 0) begin
                    settle();
                    write_reg(CFG_BINS_IN_USE, DATA_W'($urandom_range(1, 64)));
                end
                s = make_sample(k == pass_len - 1 && $urandom_range(0, 7) != 0);
                random_items++;
                send_sample(s);
            end
        end
    endtask

    initial begin
        foreach (tally[i]) tally[i] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_range();
        test_full_scale_extremes();
        test_bin_count_limits();
        test_inverted_and_flat_ranges();
        test_bins_shrunk_mid_pass();
        test_spare_register();
        test_random_passes();
        settle();

        $display("ran %0d sample requests over %0d readout passes, %0d bin requests checked",
                 sent_requests, passes_done, results_checked);
        $display("directed edges, clamped bin counts, flat and inverted ranges, %0d mismatches",
                 mismatches);
        if (mismatches == 0 && pending_bins.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
